// ----- design/i2c_mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2c master bit engine package
// phase codes and command codes shared by the engine and its testbench
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

	localparam int unsigned TPH_W = 10;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_SDA  = 4'd1,
		PH_ST_SCL  = 4'd2,
		PH_RS_HIGH = 4'd3,
		PH_RS_SDA  = 4'd4,
		PH_RS_SCL  = 4'd5,
		PH_WR_HIGH = 4'd6,
		PH_WR_LOW  = 4'd7,
		PH_WA_HIGH = 4'd8,
		PH_WA_LOW  = 4'd9,
		PH_RD_HIGH = 4'd10,
		PH_RD_LOW  = 4'd11,
		PH_RA_HIGH = 4'd12,
		PH_RA_LOW  = 4'd13,
		PH_SP_HIGH = 4'd14,
		PH_SP_REL  = 4'd15
	} phase_t;

	typedef enum logic [2:0] {
		FUNC_START   = 3'd0,
		FUNC_RESTART = 3'd1,
		FUNC_WRITE   = 3'd2,
		FUNC_READ    = 3'd3,
		FUNC_STOP    = 3'd4
	} func_t;

endpackage

// ----- design/i2c_master_bit_engine_top.sv -----
// a beat passes the input register, then the state and result registers
// throughput: one beat per cycle when not stalled, one result per input beat
// the pace is set by the single state update between input and result registers
// output stall backs up into the input register and then into in_stall
// reset: arst_n clears the engine to idle, scl and sda released, hold of one tick
// ----------------------------------------------------------------------------
// i2c master bit engine
// one input beat per bus tick, drives scl and open-drain sda per command
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top
	import i2c_mbe_pkg::*;
#(
	parameter int unsigned HOLD_COUNT_BITS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TPH_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cmd_valid,
	input  logic [2:0]       func,
	input  logic [6:0]       address,
	input  logic             rw,
	input  logic [7:0]       write_byte,
	input  logic             last_read,
	input  logic             sda_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             scl,
	output logic             sda_release,
	output logic             busy_res,
	output logic             done_res,
	output logic             acked,
	output logic [7:0]       read_data,
	output logic             rejected
);

	localparam int unsigned HCB = HOLD_COUNT_BITS;
	localparam int unsigned CW  = ((HCB > TPH_W) ? HCB : TPH_W) + 1;

	// configuration
	logic [TPH_W-1:0] tph_q;

	// input register
	logic       valid_s1;
	logic       cmd_valid_s1;
	logic [2:0] func_s1;
	logic [6:0] address_s1;
	logic       rw_s1;
	logic [7:0] write_byte_s1;
	logic       last_read_s1;
	logic       sda_in_s1;

	// engine state, also the result fields
	phase_t         phase_q, phase_d;
	logic [HCB-1:0] hold_q, hold_d;
	logic [2:0]     bit_idx_q, bit_idx_d;
	logic [7:0]     shift_q, shift_d;
	logic           end_q, end_d;
	logic           scl_q, scl_d;
	logic           sda_q, sda_d;
	logic           ack_q, ack_d;
	logic [7:0]     rx_q, rx_d;
	logic           done_d, rej_d;

	// result register
	logic out_valid_s2;
	logic done_s2;
	logic rej_s2;

	logic           adv;
	logic [HCB-1:0] hold_inc;
	logic [CW-1:0]  cap;
	logic [CW-1:0]  h_len;
	logic           hold_end;
	logic [2:0]     bit_dec;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tph_q <= TPH_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			tph_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_valid_s1  <= cmd_valid;
			func_s1       <= func;
			address_s1    <= address;
			rw_s1         <= rw;
			write_byte_s1 <= write_byte;
			last_read_s1  <= last_read;
			sda_in_s1     <= sda_in;
		end
	end

	// hold period length, zero acts as one, capped at the counter range
	always_comb begin
		cap = CW'(1) << HCB;
		if (tph_q == '0) begin
			h_len = CW'(1);
		end else begin
			h_len = CW'(tph_q);
		end
		if (h_len > cap) begin
			h_len = cap;
		end
	end

	assign hold_inc = hold_q + HCB'(1);
	assign hold_end = (hold_inc == '0) || (CW'(hold_inc) >= h_len);
	assign bit_dec  = bit_idx_q - 3'd1;

	always_comb begin
		phase_d   = phase_q;
		hold_d    = hold_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		end_d     = end_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		ack_d     = ack_q;
		rx_d      = rx_q;
		done_d    = 1'b0;
		rej_d     = 1'b0;
		if (phase_q != PH_IDLE) begin
			rej_d  = cmd_valid_s1;
			hold_d = hold_inc;
			if (hold_end) begin
				hold_d = '0;
				unique case (phase_q)
					PH_ST_SDA, PH_RS_SDA: begin
						scl_d   = 1'b0;
						phase_d = (phase_q == PH_ST_SDA) ? PH_ST_SCL : PH_RS_SCL;
					end
					PH_ST_SCL, PH_RS_SCL: begin
						bit_idx_d = 3'd7;
						sda_d     = shift_q[7];
						scl_d     = 1'b1;
						phase_d   = PH_WR_HIGH;
					end
					PH_RS_HIGH: begin
						sda_d   = 1'b0;
						phase_d = PH_RS_SDA;
					end
					PH_WR_HIGH: begin
						scl_d   = 1'b0;
						phase_d = PH_WR_LOW;
					end
					PH_WR_LOW: begin
						scl_d = 1'b1;
						if (bit_idx_q == 3'd0) begin
							sda_d   = 1'b1;
							phase_d = PH_WA_HIGH;
						end else begin
							bit_idx_d = bit_dec;
							sda_d     = shift_q[bit_dec];
							phase_d   = PH_WR_HIGH;
						end
					end
					PH_WA_HIGH: begin
						ack_d   = !sda_in_s1;
						scl_d   = 1'b0;
						phase_d = PH_WA_LOW;
					end
					PH_RD_HIGH: begin
						shift_d = {shift_q[6:0], sda_in_s1};
						scl_d   = 1'b0;
						phase_d = PH_RD_LOW;
					end
					PH_RD_LOW: begin
						scl_d = 1'b1;
						if (bit_idx_q == 3'd0) begin
							rx_d    = shift_q;
							sda_d   = end_q;
							phase_d = PH_RA_HIGH;
						end else begin
							bit_idx_d = bit_dec;
							phase_d   = PH_RD_HIGH;
						end
					end
					PH_RA_HIGH: begin
						scl_d   = 1'b0;
						phase_d = PH_RA_LOW;
					end
					PH_WA_LOW, PH_RA_LOW: begin
						sda_d   = 1'b1;
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
					PH_SP_HIGH: begin
						sda_d   = 1'b1;
						phase_d = PH_SP_REL;
					end
					default: begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
				endcase
			end
		end else if (cmd_valid_s1) begin
			hold_d = '0;
			unique case (func_s1)
				FUNC_START: begin
					shift_d = {address_s1, rw_s1};
					sda_d   = 1'b0;
					phase_d = PH_ST_SDA;
				end
				FUNC_RESTART: begin
					shift_d = {address_s1, rw_s1};
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = PH_RS_HIGH;
				end
				FUNC_WRITE: begin
					shift_d   = write_byte_s1;
					bit_idx_d = 3'd7;
					sda_d     = write_byte_s1[7];
					scl_d     = 1'b1;
					phase_d   = PH_WR_HIGH;
				end
				FUNC_READ: begin
					shift_d   = 8'd0;
					bit_idx_d = 3'd7;
					end_d     = last_read_s1;
					sda_d     = 1'b1;
					scl_d     = 1'b1;
					phase_d   = PH_RD_HIGH;
				end
				FUNC_STOP: begin
					sda_d   = 1'b0;
					scl_d   = 1'b1;
					phase_d = PH_SP_HIGH;
				end
				default: begin
					hold_d = hold_q;
					rej_d  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hold_q       <= '0;
			bit_idx_q    <= 3'd0;
			shift_q      <= 8'd0;
			end_q        <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			ack_q        <= 1'b0;
			rx_q         <= 8'd0;
			out_valid_s2 <= 1'b0;
			done_s2      <= 1'b0;
			rej_s2       <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q   <= phase_d;
				hold_q    <= hold_d;
				bit_idx_q <= bit_idx_d;
				shift_q   <= shift_d;
				end_q     <= end_d;
				scl_q     <= scl_d;
				sda_q     <= sda_d;
				ack_q     <= ack_d;
				rx_q      <= rx_d;
				done_s2   <= done_d;
				rej_s2    <= rej_d;
			end
		end
	end

	assign out_valid   = out_valid_s2;
	assign scl         = scl_q;
	assign sda_release = sda_q;
	assign busy_res    = (phase_q != PH_IDLE);
	assign done_res    = done_s2;
	assign acked       = ack_q;
	assign read_data   = rx_q;
	assign rejected    = rej_s2;

`ifndef SYNTHESIS
	// a finished command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("done reported while still busy");

	// an idle engine keeps a cleared hold counter
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (hold_q == '0))
		else $error("hold counter not cleared while idle");

	// input side stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// scl is low while the acknowledge low phase runs
	a_ack_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WA_LOW || phase_q == PH_RA_LOW) |-> !scl_q)
		else $error("scl high in acknowledge low phase");
`endif

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// i2c master bit engine testbench
// Each input beat is one bus tick carrying an optional command and the
// sampled sda level. A behavioural copy of the engine runs alongside the
// block and predicts the pin levels and status flags for every tick. Each
// result beat is checked against that prediction, field by field.
// Covered: every command, unknown function codes, commands arriving while
// busy, the reset hold and the extreme hold settings, then random
// transfers mixed with noise. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import i2c_mbe_pkg::*;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] func;
		logic [6:0] address;
		logic       rw;
		logic [7:0] write_byte;
		logic       last_read;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda_rel;
		logic       busy;
		logic       done;
		logic       acked;
		logic [7:0] rdata;
		logic       rej;
	} bus_state_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [TPH_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             cmd_valid;
	logic [2:0]       func;
	logic [6:0]       address;
	logic             rw;
	logic [7:0]       write_byte;
	logic             last_read;
	logic             sda_in;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             scl;
	logic             sda_release;
	logic             busy_res;
	logic             done_res;
	logic             acked;
	logic [7:0]       read_data;
	logic             rejected;

	// engine copy
	logic [TPH_W-1:0] hold_reg;
	phase_t           ph;
	logic [9:0]       hcnt;
	logic [2:0]       bidx;
	logic [7:0]       sreg;
	func_t            cur_cmd;
	logic             efl;
	logic             scl_l;
	logic             sda_l;
	logic             ackf;
	logic [7:0]       rxb;

	bus_state_t bus_state_q[$];
	int         ticks_sent = 0;
	int         mismatches = 0;
	logic       calm = 1'b0;

	i2c_master_bit_engine_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd_valid   (cmd_valid),
		.func        (func),
		.address     (address),
		.rw          (rw),
		.write_byte  (write_byte),
		.last_read   (last_read),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl         (scl),
		.sda_release (sda_release),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.acked       (acked),
		.read_data   (read_data),
		.rejected    (rejected)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------- engine copy

	function automatic void drive_bit();
		sda_l = sreg[bidx];
		scl_l = 1'b1;
		ph = PH_WR_HIGH;
	endfunction

	// end of one hold period, returns 1 when the command completes
	function automatic logic hold_done(input logic sda);
		logic fin;
		fin = 1'b0;
		case (ph)
			PH_ST_SDA: begin scl_l = 1'b0; ph = PH_ST_SCL; end
			PH_ST_SCL: begin bidx = 3'd7; drive_bit(); end
			PH_RS_HIGH: begin sda_l = 1'b0; ph = PH_RS_SDA; end
			PH_RS_SDA: begin scl_l = 1'b0; ph = PH_RS_SCL; end
			PH_RS_SCL: begin bidx = 3'd7; drive_bit(); end
			PH_WR_HIGH: begin scl_l = 1'b0; ph = PH_WR_LOW; end
			PH_WR_LOW: begin
				if (bidx == 3'd0) begin
					sda_l = 1'b1;
					scl_l = 1'b1;
					ph = PH_WA_HIGH;
				end else begin
					bidx = bidx - 3'd1;
					drive_bit();
				end
			end
			PH_WA_HIGH: begin ackf = ~sda; scl_l = 1'b0; ph = PH_WA_LOW; end
			PH_WA_LOW: begin sda_l = 1'b1; fin = 1'b1; end
			PH_RD_HIGH: begin
				sreg = {sreg[6:0], sda};
				scl_l = 1'b0;
				ph = PH_RD_LOW;
			end
			PH_RD_LOW: begin
				scl_l = 1'b1;
				if (bidx == 3'd0) begin
					rxb = sreg;
					sda_l = efl;
					ph = PH_RA_HIGH;
				end else begin
					bidx = bidx - 3'd1;
					ph = PH_RD_HIGH;
				end
			end
			PH_RA_HIGH: begin scl_l = 1'b0; ph = PH_RA_LOW; end
			PH_RA_LOW: begin sda_l = 1'b1; fin = 1'b1; end
			PH_SP_HIGH: begin sda_l = 1'b1; ph = PH_SP_REL; end
			default: fin = 1'b1;
		endcase
		if (fin) begin
			ph = PH_IDLE;
			hcnt = '0;
		end
		return fin;
	endfunction

	function automatic bus_state_t next_bus_state(input tick_t t);
		bus_state_t  r;
		logic        fin;
		logic        rej;
		int unsigned hlen;
		fin = 1'b0;
		rej = 1'b0;
		if (ph != PH_IDLE) begin
			hcnt = hcnt + 10'd1;
			// zero hold behaves as one tick
			hlen = (hold_reg == '0) ? 1 : hold_reg;
			if (hcnt == '0 || hcnt >= hlen) begin
				hcnt = '0;
				fin = hold_done(t.sda_in);
			end
			if (t.cmd_valid)
				rej = 1'b1;
		end else if (t.cmd_valid) begin
			if (t.func > FUNC_STOP) begin
				rej = 1'b1;
			end else begin
				cur_cmd = func_t'(t.func);
				hcnt = '0;
				case (t.func)
					FUNC_START: begin
						sreg = {t.address, t.rw};
						sda_l = 1'b0;
						ph = PH_ST_SDA;
					end
					FUNC_RESTART: begin
						sreg = {t.address, t.rw};
						sda_l = 1'b1;
						scl_l = 1'b1;
						ph = PH_RS_HIGH;
					end
					FUNC_WRITE: begin
						sreg = t.write_byte;
						bidx = 3'd7;
						drive_bit();
					end
					FUNC_READ: begin
						sreg = '0;
						bidx = 3'd7;
						efl = t.last_read;
						sda_l = 1'b1;
						scl_l = 1'b1;
						ph = PH_RD_HIGH;
					end
					default: begin
						sda_l = 1'b0;
						scl_l = 1'b1;
						ph = PH_SP_HIGH;
					end
				endcase
			end
		end
		r.scl = scl_l;
		r.sda_rel = sda_l;
		r.busy = (ph != PH_IDLE);
		r.done = fin;
		r.acked = ackf;
		r.rdata = rxb;
		r.rej = rej;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		if (mismatches < 50)
			$display("tb_top: %0t mismatch %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 30);
	end

	always @(posedge clk) begin : result_check
		bus_state_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bus_state_q.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = bus_state_q.pop_front();
				if (scl !== want.scl) report_mismatch("scl", scl, want.scl);
				if (sda_release !== want.sda_rel)
					report_mismatch("sda_release", sda_release, want.sda_rel);
				if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
				if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
				if (acked !== want.acked) report_mismatch("acked", acked, want.acked);
				if (read_data !== want.rdata)
					report_mismatch("read_data", read_data, want.rdata);
				if (rejected !== want.rej) report_mismatch("rejected", rejected, want.rej);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic pick_sda(input int mode);
		if (mode == 0)
			return 1'b0;
		if (mode == 1)
			return 1'b1;
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic tick_t rand_tick(input logic cv, input int sda_mode);
		tick_t t;
		t.cmd_valid = cv;
		t.func = 3'($urandom_range(0, 7));
		t.address = 7'($urandom_range(0, 127));
		t.rw = 1'($urandom_range(0, 1));
		t.write_byte = 8'($urandom_range(0, 255));
		t.last_read = 1'($urandom_range(0, 1));
		t.sda_in = pick_sda(sda_mode);
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(0, 99) < 30) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid   <= 1'b1;
		cmd_valid  <= t.cmd_valid;
		func       <= t.func;
		address    <= t.address;
		rw         <= t.rw;
		write_byte <= t.write_byte;
		last_read  <= t.last_read;
		sda_in     <= t.sda_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bus_state_q.push_back(next_bus_state(t));
		ticks_sent++;
	endtask

	// one command, then ticks until the engine is idle again
	task automatic run_cmd(input func_t f, input logic [6:0] a, input logic r,
		input logic [7:0] wb, input logic lr, input int sda_mode, input int noise_pct);
		tick_t t;
		t = rand_tick(1'b1, sda_mode);
		t.func = f;
		t.address = a;
		t.rw = r;
		t.write_byte = wb;
		t.last_read = lr;
		send_tick(t);
		while (ph != PH_IDLE)
			send_tick(rand_tick($urandom_range(0, 99) < noise_pct, sda_mode));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bus_state_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_hold(input logic [TPH_W-1:0] v);
		while (ph != PH_IDLE)
			send_tick(rand_tick(1'b0, 2));
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		hold_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_reset_hold();
		repeat (3) send_tick(rand_tick(1'b0, 2));
		run_cmd(FUNC_START, 7'h00, 1'b0, 8'h00, 1'b0, 0, 0);
	endtask

	task automatic test_each_command();
		set_hold(10'd2);
		run_cmd(FUNC_START, 7'h7f, 1'b1, 8'h00, 1'b0, 1, 0);
		run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'h00, 1'b0, 0, 0);
		run_cmd(FUNC_WRITE, 7'h7f, 1'b1, 8'hff, 1'b1, 1, 0);
		run_cmd(FUNC_RESTART, 7'h55, 1'b0, 8'ha5, 1'b0, 0, 0);
		run_cmd(FUNC_READ, 7'h2a, 1'b1, 8'h5a, 1'b0, 1, 0);
		run_cmd(FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b1, 0, 0);
		run_cmd(FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b1, 2, 0);
		run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 2, 0);
	endtask

	task automatic test_unknown_func();
		tick_t t;
		for (int f = 5; f <= 7; f++) begin
			t = rand_tick(1'b1, 2);
			t.func = 3'(f);
			send_tick(t);
		end
		send_tick(rand_tick(1'b0, 2));
	endtask

	// a command on every tick: rejects while busy, including the finishing tick
	task automatic test_busy_collision();
		run_cmd(FUNC_WRITE, 7'h11, 1'b0, 8'h3c, 1'b0, 2, 100);
		run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 2, 100);
	endtask

	task automatic test_hold_extremes();
		set_hold(10'd0);
		run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'h96, 1'b0, 2, 5);
		set_hold(10'd3);
		run_cmd(FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b1, 2, 5);
		set_hold(10'd64);
		run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 2, 1);
	endtask

	task automatic random_transfer();
		int n;
		int mode;
		n = $urandom_range(1, 3);
		mode = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2;
		run_cmd(FUNC_START, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 8'h00,
			1'b0, mode, 3);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				run_cmd(FUNC_RESTART, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
					8'h00, 1'b0, mode, 3);
			if ($urandom_range(0, 1))
				run_cmd(FUNC_WRITE, 7'h00, 1'b0, 8'($urandom_range(0, 255)), 1'b0, mode, 3);
			else
				run_cmd(FUNC_READ, 7'h00, 1'b0, 8'h00, 1'($urandom_range(0, 1)), mode, 3);
		end
		run_cmd(FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, mode, 3);
	endtask

	task automatic test_random_traffic();
		int base;
		int last_cfg;
		base = ticks_sent;
		last_cfg = ticks_sent;
		set_hold(10'd1);
		while (ticks_sent < 1300) begin
			if (ticks_sent - last_cfg > 150) begin
				case ($urandom_range(0, 5))
					0: set_hold(10'd0);
					1, 2: set_hold(10'd1);
					3: set_hold(10'd2);
					4: set_hold(10'd3);
					default: set_hold(TPH_W'($urandom_range(4, 6)));
				endcase
				last_cfg = ticks_sent;
			end
			// a stretch with no idling on either side
			calm = (ticks_sent - base >= 200) && (ticks_sent - base < 500);
			if ($urandom_range(0, 99) < 80) begin
				random_transfer();
			end else begin
				repeat ($urandom_range(1, 8))
					send_tick(rand_tick(1'($urandom_range(0, 1)), 2));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		cmd_valid  = 1'b0;
		func       = '0;
		address    = '0;
		rw         = 1'b0;
		write_byte = '0;
		last_read  = 1'b0;
		sda_in     = 1'b1;
		hold_reg   = 10'd1;
		ph         = PH_IDLE;
		hcnt       = '0;
		bidx       = '0;
		sreg       = '0;
		cur_cmd    = FUNC_START;
		efl        = 1'b0;
		scl_l      = 1'b1;
		sda_l      = 1'b1;
		ackf       = 1'b0;
		rxb        = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_hold();
		test_each_command();
		test_unknown_func();
		test_busy_collision();
		test_hold_extremes();
		test_random_traffic();

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
